[rtl/core/min_jerk_quintic_coeffs_assert.svh]
// Assertion macros for the checker file mjq_chk.
`ifndef MIN_JERK_QUINTIC_COEFFS_ASSERT_SVH
`define MIN_JERK_QUINTIC_COEFFS_ASSERT_SVH

// same-cycle implication, held off during reset
`define MJQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MJQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset is sampled
`define MJQ_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

[rtl/core/mjq_pkg.sv]
// ----------------------------------------------------------------------------
// mjq_pkg
// Types, constants and saturating arithmetic for the quintic coefficient pipe.
// ----------------------------------------------------------------------------
package mjq_pkg;

  localparam int DUR_W     = 21;
  localparam int VAL_W     = 64;
  localparam int OUT_W     = 48;
  localparam int NCOEF     = 6;
  localparam int NLANE     = 3;
  localparam int FRAC      = 16;
  localparam int QBITS     = 62;
  localparam int CAP_SH    = QBITS - FRAC;
  localparam int STEP_BITS = 2;
  localparam int NSTEP     = QBITS / STEP_BITS;
  localparam int REM_W     = DUR_W;

  localparam logic [DUR_W-1:0] DUR_MIN = 21'd16384;
  localparam logic [DUR_W-1:0] DUR_MAX = 21'd1048576;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t v;
    logic ov;
  } sres_t;

  typedef struct packed {
    logic [OUT_W-1:0] v;
    logic             ov;
  } ores_t;

  // one item in flight: duration, six coefficients, sticky saturation flag
  typedef struct packed {
    logic [DUR_W-1:0]            dur;
    logic [NCOEF-1:0][VAL_W-1:0] coef;
    logic                        ov;
  } pipe_t;

  function automatic sres_t sat64(input logic signed [127:0] x);
    sres_t r;
    if ((&x[127:VAL_W-1]) || !(|x[127:VAL_W-1])) begin
      r.v  = x[VAL_W-1:0];
      r.ov = 1'b0;
    end else begin
      r.v  = x[127] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      r.ov = 1'b1;
    end
    return r;
  endfunction

  function automatic sres_t sadd(input val_t a, input val_t b);
    return sat64(128'(a) + 128'(b));
  endfunction

  // wraps on the most negative value
  function automatic val_t neg64(input val_t a);
    return -a;
  endfunction

  function automatic sres_t smul(input val_t a, input logic signed [7:0] k);
    return sat64(128'(a) * 128'(k));
  endfunction

  function automatic ores_t emit(input val_t x);
    ores_t r;
    if ((&x[VAL_W-1:OUT_W-1]) || !(|x[VAL_W-1:OUT_W-1])) begin
      r.v  = x[OUT_W-1:0];
      r.ov = 1'b0;
    end else begin
      r.v  = x[VAL_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      r.ov = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/core/min_jerk_quintic_coeffs.sv]
// Pipeline from input transfer to result: 6 front-end stages,
// five divider passes of 33 stages each, one output register.
// Throughput: one item per cycle while the output is not stalled; the 2-bit-per-stage restoring dividers set the depth.
// A stalled output register freezes the whole pipe; nothing is dropped.
// Reset (rst_n low, synchronous) clears every valid bit; data registers keep their contents.
// ----------------------------------------------------------------------------
// min_jerk_quintic_coeffs
// Minimum-jerk quintic coefficients from start/end state and duration.
// ----------------------------------------------------------------------------
module min_jerk_quintic_coeffs #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  in_start_pos,
  input  logic signed [DATA_WIDTH-1:0]  in_start_vel,
  input  logic signed [DATA_WIDTH-1:0]  in_start_acc,
  input  logic signed [DATA_WIDTH-1:0]  in_end_pos,
  input  logic signed [DATA_WIDTH-1:0]  in_end_vel,
  input  logic signed [DATA_WIDTH-1:0]  in_end_acc,
  input  logic [mjq_pkg::DUR_W-1:0]     in_duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [mjq_pkg::OUT_W-1:0] out_coef0,
  output logic signed [mjq_pkg::OUT_W-1:0] out_coef1,
  output logic signed [mjq_pkg::OUT_W-1:0] out_coef2,
  output logic signed [mjq_pkg::OUT_W-1:0] out_coef3,
  output logic signed [mjq_pkg::OUT_W-1:0] out_coef4,
  output logic signed [mjq_pkg::OUT_W-1:0] out_coef5,
  output logic                          out_overflow
);
  import mjq_pkg::*;

  localparam int NRND = 5;

  logic  en;
  logic  rnd_vld [0:NRND];
  pipe_t rnd_p   [0:NRND];

  logic             out_valid_r;
  logic [OUT_W-1:0] coef_r [NCOEF];
  logic             ov_r;

  ores_t            e   [NCOEF];
  logic             e_ov;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  mjq_front #(.DW(DATA_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .start_pos (in_start_pos),
    .start_vel (in_start_vel),
    .start_acc (in_start_acc),
    .end_pos   (in_end_pos),
    .end_vel   (in_end_vel),
    .end_acc   (in_end_acc),
    .dur       (in_duration),
    .out_vld   (rnd_vld[0]),
    .out_p     (rnd_p[0])
  );

  // coef3 needs three passes, coef4 four, coef5 five
  for (genvar r = 0; r < NRND; r++) begin : g_rnd
    localparam logic [2:0] ACT = (r < 3) ? 3'b111 : ((r == 3) ? 3'b110 : 3'b100);
    mjq_div #(.ACTIVE(ACT)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (rnd_vld[r]),
      .in_p    (rnd_p[r]),
      .out_vld (rnd_vld[r+1]),
      .out_p   (rnd_p[r+1])
    );
  end

  always_comb begin
    e_ov = rnd_p[NRND].ov;
    for (int k = 0; k < NCOEF; k++) begin
      e[k] = emit(rnd_p[NRND].coef[k]);
      e_ov = e_ov | e[k].ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rnd_vld[NRND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCOEF; k++) begin
        coef_r[k] <= e[k].v;
      end
      ov_r <= e_ov;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_coef0    = coef_r[0];
  assign out_coef1    = coef_r[1];
  assign out_coef2    = coef_r[2];
  assign out_coef3    = coef_r[3];
  assign out_coef4    = coef_r[4];
  assign out_coef5    = coef_r[5];
  assign out_overflow = ov_r;

endmodule

[rtl/core/mjq_front.sv]
// ----------------------------------------------------------------------------
// mjq_front
// Six-stage front end: residuals h0/h1/h2, u = h1*T, q = h2*T^2/2 and the
// numerators of the three upper coefficients, all saturating to 64 bits.
// Wide products by the duration are built from 32-bit slices over two stages.
// ----------------------------------------------------------------------------
module mjq_front #(
  parameter int DW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [DW-1:0]          start_pos,
  input  logic signed [DW-1:0]          start_vel,
  input  logic signed [DW-1:0]          start_acc,
  input  logic signed [DW-1:0]          end_pos,
  input  logic signed [DW-1:0]          end_vel,
  input  logic signed [DW-1:0]          end_acc,
  input  logic [mjq_pkg::DUR_W-1:0]     dur,
  output logic                          out_vld,
  output mjq_pkg::pipe_t                out_p
);
  import mjq_pkg::*;

  localparam logic signed [7:0] K3_H0 = 8'sd10;
  localparam logic signed [7:0] K3_U  = -8'sd4;
  localparam logic signed [7:0] K4_H0 = -8'sd15;
  localparam logic signed [7:0] K4_U  = 8'sd7;
  localparam logic signed [7:0] K4_Q  = -8'sd2;
  localparam logic signed [7:0] K5_H0 = 8'sd6;
  localparam logic signed [7:0] K5_U  = -8'sd3;

  localparam int DS_W  = DUR_W + 1;      // duration as a signed operand
  localparam int AD_W  = DW + DS_W;      // a0*d
  localparam int AH_W  = AD_W - 32;      // upper slice of a0*d
  localparam int ADD_W = AD_W + DS_W;    // a0*d*d
  localparam int HD_W  = VAL_W + DS_W;   // h2*d and h1*d
  localparam int HH_W  = HD_W - 64;      // top slice of h2*d
  localparam int QD_W  = HD_W + DS_W;    // h2*d*d
  localparam int PL_W  = 33 + DS_W;      // zero-extended 32-bit slice times d
  localparam int PH_W  = 32 + DS_W;      // signed 32-bit slice times d

  // ---- stage 1 ----
  logic [DUR_W-1:0]          d_c;
  logic signed [DS_W-1:0]    d_s1;
  logic signed [AD_W-1:0]    vd_p, ad_p;
  sres_t hp_s, hv_s, h2_s, vd_s, ad_s, c0_s, c1_s, c2_s;

  logic                      s1_vld_r;
  logic [DUR_W-1:0]          s1_d_r;
  val_t                      s1_hp_r, s1_hv_r, s1_h2_r, s1_vd_r, s1_ads_r;
  logic signed [AD_W-1:0]    s1_ad_r;
  val_t                      s1_c0_r, s1_c1_r, s1_c2_r;
  logic                      s1_ov_r;

  always_comb begin
    if (dur < DUR_MIN) begin
      d_c = DUR_MIN;
    end else if (dur > DUR_MAX) begin
      d_c = DUR_MAX;
    end else begin
      d_c = dur;
    end
    d_s1 = $signed({1'b0, d_c});
    vd_p = start_vel * d_s1;
    ad_p = start_acc * d_s1;
    hp_s = sat64((128'(end_pos) - 128'(start_pos)) <<< FRAC);
    hv_s = sat64((128'(end_vel) - 128'(start_vel)) <<< FRAC);
    h2_s = sat64((128'(end_acc) - 128'(start_acc)) <<< FRAC);
    vd_s = sat64(128'(vd_p));
    ad_s = sat64(128'(ad_p));
    c0_s = sat64(128'(start_pos) <<< FRAC);
    c1_s = sat64(128'(start_vel) <<< FRAC);
    c2_s = sat64(128'(start_acc) <<< (FRAC - 1));
  end

  // ---- stage 2: residual sums, slices of a0*d*d and h2*d ----
  logic signed [DS_W-1:0]       d_s2;
  sres_t                        h0a_s, h1_s;
  logic signed [PL_W-1:0]       adl_p, h2l_p;
  logic signed [AH_W+DS_W-1:0]  adh_p;
  logic signed [PH_W-1:0]       h2h_p;

  logic                         s2_vld_r;
  logic [DUR_W-1:0]             s2_d_r;
  val_t                         s2_h0a_r, s2_h1_r;
  logic signed [PL_W-1:0]       s2_adl_r, s2_h2l_r;
  logic signed [AH_W+DS_W-1:0]  s2_adh_r;
  logic signed [PH_W-1:0]       s2_h2h_r;
  val_t                         s2_c0_r, s2_c1_r, s2_c2_r;
  logic                         s2_ov_r;

  always_comb begin
    d_s2  = $signed({1'b0, s1_d_r});
    h0a_s = sadd(s1_hp_r, neg64(s1_vd_r));
    h1_s  = sadd(s1_hv_r, neg64(s1_ads_r));
    adl_p = $signed({1'b0, s1_ad_r[31:0]}) * d_s2;
    adh_p = $signed(s1_ad_r[AD_W-1:32]) * d_s2;
    h2l_p = $signed({1'b0, s1_h2_r[31:0]}) * d_s2;
    h2h_p = $signed(s1_h2_r[VAL_W-1:32]) * d_s2;
  end

  // ---- stage 3: h0, h2*d, slices of h1*d ----
  logic signed [DS_W-1:0]  d_s3;
  logic signed [ADD_W-1:0] add_p;
  logic signed [HD_W-1:0]  h2d_p;
  sres_t                   t17_s, h0_s;
  logic signed [PL_W-1:0]  ul_p;
  logic signed [PH_W-1:0]  uh_p;

  logic                    s3_vld_r;
  logic [DUR_W-1:0]        s3_d_r;
  val_t                    s3_h0_r;
  logic signed [HD_W-1:0]  s3_h2d_r;
  logic signed [PL_W-1:0]  s3_ul_r;
  logic signed [PH_W-1:0]  s3_uh_r;
  val_t                    s3_c0_r, s3_c1_r, s3_c2_r;
  logic                    s3_ov_r;

  always_comb begin
    d_s3  = $signed({1'b0, s2_d_r});
    add_p = (ADD_W'(s2_adh_r) <<< 32) + ADD_W'(s2_adl_r);
    t17_s = sat64(128'(add_p >>> 17));
    h0_s  = sadd(s2_h0a_r, neg64(t17_s.v));
    h2d_p = (HD_W'(s2_h2h_r) <<< 32) + HD_W'(s2_h2l_r);
    ul_p  = $signed({1'b0, s2_h1_r[31:0]}) * d_s3;
    uh_p  = $signed(s2_h1_r[VAL_W-1:32]) * d_s3;
  end

  // ---- stage 4: u, slices of h2*d*d ----
  logic signed [DS_W-1:0]       d_s4;
  logic signed [HD_W-1:0]       ud_p;
  sres_t                        u_s;
  logic signed [PL_W-1:0]       q0_p, q1_p;
  logic signed [HH_W+DS_W-1:0]  q2_p;

  logic                         s4_vld_r;
  logic [DUR_W-1:0]             s4_d_r;
  val_t                         s4_h0_r, s4_u_r;
  logic signed [PL_W-1:0]       s4_q0_r, s4_q1_r;
  logic signed [HH_W+DS_W-1:0]  s4_q2_r;
  val_t                         s4_c0_r, s4_c1_r, s4_c2_r;
  logic                         s4_ov_r;

  always_comb begin
    d_s4 = $signed({1'b0, s3_d_r});
    ud_p = (HD_W'(s3_uh_r) <<< 32) + HD_W'(s3_ul_r);
    u_s  = sat64(128'(ud_p >>> FRAC));
    q0_p = $signed({1'b0, s3_h2d_r[31:0]}) * d_s4;
    q1_p = $signed({1'b0, s3_h2d_r[63:32]}) * d_s4;
    q2_p = $signed(s3_h2d_r[HD_W-1:64]) * d_s4;
  end

  // ---- stage 5: q ----
  logic signed [QD_W-1:0] qd_p;
  sres_t                  q_s;

  logic                   s5_vld_r;
  logic [DUR_W-1:0]       s5_d_r;
  val_t                   s5_h0_r, s5_u_r, s5_q_r;
  val_t                   s5_c0_r, s5_c1_r, s5_c2_r;
  logic                   s5_ov_r;

  always_comb begin
    qd_p = (QD_W'(s4_q2_r) <<< 64) + (QD_W'(s4_q1_r) <<< 32) + QD_W'(s4_q0_r);
    q_s  = sat64(128'(qd_p >>> 33));
  end

  // ---- stage 6: numerators ----
  sres_t m3a, m3b, a3, n3, m4a, m4b, m4c, a4, n4, m5a, m5b, a5, n5;
  logic  ov4;
  pipe_t p_nxt;
  logic  s6_vld_r;
  pipe_t s6_p_r;

  always_comb begin
    m3a = smul(s5_h0_r, K3_H0);
    m3b = smul(s5_u_r, K3_U);
    a3  = sadd(m3a.v, m3b.v);
    n3  = sadd(a3.v, s5_q_r);
    m4a = smul(s5_h0_r, K4_H0);
    m4b = smul(s5_u_r, K4_U);
    m4c = smul(s5_q_r, K4_Q);
    a4  = sadd(m4a.v, m4b.v);
    n4  = sadd(a4.v, m4c.v);
    m5a = smul(s5_h0_r, K5_H0);
    m5b = smul(s5_u_r, K5_U);
    a5  = sadd(m5a.v, m5b.v);
    n5  = sadd(a5.v, s5_q_r);
    ov4 = m3a.ov | m3b.ov | a3.ov | n3.ov | m4a.ov | m4b.ov | m4c.ov | a4.ov |
          n4.ov | m5a.ov | m5b.ov | a5.ov | n5.ov;
    p_nxt.dur     = s5_d_r;
    p_nxt.coef[0] = s5_c0_r;
    p_nxt.coef[1] = s5_c1_r;
    p_nxt.coef[2] = s5_c2_r;
    p_nxt.coef[3] = n3.v;
    p_nxt.coef[4] = n4.v;
    p_nxt.coef[5] = n5.v;
    p_nxt.ov      = s5_ov_r | ov4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r   <= d_c;
      s1_hp_r  <= hp_s.v;
      s1_hv_r  <= hv_s.v;
      s1_h2_r  <= h2_s.v;
      s1_vd_r  <= vd_s.v;
      s1_ads_r <= ad_s.v;
      s1_ad_r  <= ad_p;
      s1_c0_r  <= c0_s.v;
      s1_c1_r  <= c1_s.v;
      s1_c2_r  <= c2_s.v;
      s1_ov_r  <= hp_s.ov | hv_s.ov | h2_s.ov | vd_s.ov | ad_s.ov |
                  c0_s.ov | c1_s.ov | c2_s.ov;

      s2_d_r   <= s1_d_r;
      s2_h0a_r <= h0a_s.v;
      s2_h1_r  <= h1_s.v;
      s2_adl_r <= adl_p;
      s2_adh_r <= adh_p;
      s2_h2l_r <= h2l_p;
      s2_h2h_r <= h2h_p;
      s2_c0_r  <= s1_c0_r;
      s2_c1_r  <= s1_c1_r;
      s2_c2_r  <= s1_c2_r;
      s2_ov_r  <= s1_ov_r | h0a_s.ov | h1_s.ov;

      s3_d_r   <= s2_d_r;
      s3_h0_r  <= h0_s.v;
      s3_h2d_r <= h2d_p;
      s3_ul_r  <= ul_p;
      s3_uh_r  <= uh_p;
      s3_c0_r  <= s2_c0_r;
      s3_c1_r  <= s2_c1_r;
      s3_c2_r  <= s2_c2_r;
      s3_ov_r  <= s2_ov_r | t17_s.ov | h0_s.ov;

      s4_d_r   <= s3_d_r;
      s4_h0_r  <= s3_h0_r;
      s4_u_r   <= u_s.v;
      s4_q0_r  <= q0_p;
      s4_q1_r  <= q1_p;
      s4_q2_r  <= q2_p;
      s4_c0_r  <= s3_c0_r;
      s4_c1_r  <= s3_c1_r;
      s4_c2_r  <= s3_c2_r;
      s4_ov_r  <= s3_ov_r | u_s.ov;

      s5_d_r   <= s4_d_r;
      s5_h0_r  <= s4_h0_r;
      s5_u_r   <= s4_u_r;
      s5_q_r   <= q_s.v;
      s5_c0_r  <= s4_c0_r;
      s5_c1_r  <= s4_c1_r;
      s5_c2_r  <= s4_c2_r;
      s5_ov_r  <= s4_ov_r | q_s.ov;

      s6_p_r   <= p_nxt;
    end
  end

  assign out_vld = s6_vld_r;
  assign out_p   = s6_p_r;

endmodule

[rtl/core/mjq_div.sv]
// ----------------------------------------------------------------------------
// mjq_div
// One pipelined pass of x -> floor(x * 2^16 / d) on up to three lanes.
// Restoring division, two quotient bits per stage, saturation at +-2^62.
// ----------------------------------------------------------------------------
module mjq_div #(
  parameter logic [2:0] ACTIVE = 3'b111
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  mjq_pkg::pipe_t in_p,
  output logic           out_vld,
  output mjq_pkg::pipe_t out_p
);
  import mjq_pkg::*;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] w;   // dividend bits shift out the top, quotient bits in
  } dlane_t;

  function automatic dlane_t div_step(input dlane_t a, input logic [DUR_W-1:0] d);
    dlane_t           r;
    logic [REM_W:0]   t;
    r = a;
    for (int i = 0; i < STEP_BITS; i++) begin
      t   = {r.rem, r.w[QBITS-1]};
      r.w = {r.w[QBITS-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t      = t - {1'b0, d};
        r.w[0] = 1'b1;
      end
      r.rem = t[REM_W-1:0];
    end
    return r;
  endfunction

  logic   vld_r [0:NSTEP];
  pipe_t  p_r   [0:NSTEP];
  dlane_t ln_r  [0:NSTEP][NLANE];
  dlane_t ln_nxt[0:NSTEP][NLANE];

  logic   out_vld_r;
  pipe_t  out_p_r;
  pipe_t  fin;

  val_t             x;
  logic [VAL_W-1:0] m;
  logic [VAL_W-1:0] t;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      x = in_p.coef[3+l];
      m = x[VAL_W-1] ? (~x + 1'b1) : x;
      ln_nxt[0][l].neg = x[VAL_W-1];
      // quotient would reach 2^62 exactly when floor(m / 2^46) >= d
      ln_nxt[0][l].ovf = {{(REM_W-(VAL_W-CAP_SH)){1'b0}}, m[VAL_W-1:CAP_SH]} >= in_p.dur;
      ln_nxt[0][l].rem = REM_W'(m[VAL_W-1:CAP_SH]);
      ln_nxt[0][l].w   = {m[CAP_SH-1:0], {FRAC{1'b0}}};
    end
    for (int k = 1; k <= NSTEP; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        ln_nxt[k][l] = div_step(ln_r[k-1][l], p_r[k-1].dur);
      end
    end
  end

  always_comb begin
    fin = p_r[NSTEP];
    t   = '0;
    for (int l = 0; l < NLANE; l++) begin
      if (ACTIVE[l]) begin
        t = {2'b00, ln_r[NSTEP][l].w} +
            VAL_W'(ln_r[NSTEP][l].neg && (ln_r[NSTEP][l].rem != '0));
        if (ln_r[NSTEP][l].ovf) begin
          fin.coef[3+l] = ln_r[NSTEP][l].neg ? {2'b11, {QBITS{1'b0}}} :
                                               {2'b01, {QBITS{1'b0}}};
        end else begin
          fin.coef[3+l] = ln_r[NSTEP][l].neg ? (~t + 1'b1) : t;
        end
        fin.ov = fin.ov | ln_r[NSTEP][l].ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSTEP; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= NSTEP; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= in_p;
      for (int k = 1; k <= NSTEP; k++) begin
        p_r[k] <= p_r[k-1];
      end
      for (int k = 0; k <= NSTEP; k++) begin
        for (int l = 0; l < NLANE; l++) begin
          ln_r[k][l] <= ln_nxt[k][l];
        end
      end
      out_p_r <= fin;
    end
  end

  assign out_vld = out_vld_r;
  assign out_p   = out_p_r;

endmodule

[rtl/core/mjq_chk.sv]
// ----------------------------------------------------------------------------
// mjq_chk
// Port-level checks on the coefficient block, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_jerk_quintic_coeffs_assert.svh"

module mjq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_coef0,
  input logic [47:0] out_coef1,
  input logic [47:0] out_coef2,
  input logic [47:0] out_coef3,
  input logic        out_overflow
);

  // a waiting result keeps its value
  `MJQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_coef3) && $stable(out_overflow), "result changed while stalled")

  // input side only stalls behind a stalled output transfer
  `MJQ_ASSERT_IMP(a_stall_src, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

  // unsaturated c0, c1, c2 are scaled inputs: low bits are zero
  `MJQ_ASSERT_IMP(a_low_bits, out_valid && !out_overflow, out_coef0[15:0] == 16'd0 && out_coef1[15:0] == 16'd0 && out_coef2[14:0] == 15'd0, "low coefficient bits set without overflow")

  `MJQ_ASSERT_RST(a_rst_idle, !out_valid, "result valid right after reset")

endmodule

bind min_jerk_quintic_coeffs mjq_chk u_mjq_chk (.*);
